@@ design/pidc_pkg.sv @@
// Package for the clamped PID controller: widths, register map, state
// and operation codes, and the integral saturation helper.
// No dependencies.
package pidc_pkg;

  // Field and datapath widths
  localparam int DATA_W     = 16;   // Q8.8 error, gains, limits, output
  localparam int ACC_W      = 32;   // Q16.16 integral
  localparam int PROD_W     = 48;   // 16 x 32 signed product
  localparam int DIG_W      = 2;    // multiplier digit, bits per cycle
  localparam int MUL_STEPS  = DATA_W / DIG_W;
  localparam int MUL_CNT_W  = $clog2(MUL_STEPS);
  localparam int FRAC_DT    = 12;   // fraction bits of the time step
  localparam int NUM_W      = DATA_W + FRAC_DT;   // dividend magnitude
  localparam int DIV_CNT_W  = $clog2(NUM_W);
  localparam int DERIV_W    = NUM_W + 1;          // signed quotient
  localparam int ADDR_W     = 5;
  localparam int PDATA_W    = 32;

  // APB register map, word index
  typedef enum logic [2:0] {
    REG_GAIN_PROP  = 3'd0,
    REG_GAIN_INTEG = 3'd1,
    REG_GAIN_DERIV = 3'd2,
    REG_OUT_MAX    = 3'd3,
    REG_OUT_MIN    = 3'd4
  } reg_idx_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MUL   = 4'b0010,
    S_WDIV  = 4'b0100,
    S_CLAMP = 4'b1000
  } state_t;

  // Product being formed on the shared multiplier
  typedef enum logic [1:0] {
    OP_EDT = 2'd0,   // e * dt, integral step
    OP_KP  = 2'd1,   // kp * e
    OP_KI  = 2'd2,   // ki * integral
    OP_KD  = 2'd3    // kd * derivative
  } op_t;

  // Saturate a 34-bit sum to the signed 32-bit integral range
  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W+1:0] v);
    logic signed [ACC_W+1:0] hi;
    logic signed [ACC_W+1:0] lo;
    hi = {3'b000, {(ACC_W-1){1'b1}}};
    lo = {3'b111, {(ACC_W-1){1'b0}}};
    if (v > hi) begin
      sat_acc = {1'b0, {(ACC_W-1){1'b1}}};
    end else if (v < lo) begin
      sat_acc = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      sat_acc = v[ACC_W-1:0];
    end
  endfunction

endpackage

@@ design/pidc_if.sv @@
// Stream interfaces for the clamped PID controller: sample beats in,
// control beats out. Depends on pidc_pkg for field widths.
interface pidc_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [pidc_pkg::DATA_W-1:0]  err_sample;
  logic        [pidc_pkg::DATA_W-1:0]  step_time;

  modport source (output valid, err_sample, step_time, input ready);
  modport sink   (input valid, err_sample, step_time, output ready);
endinterface

interface pidc_control_if;
  logic                                valid;
  logic                                ready;
  logic signed [pidc_pkg::DATA_W-1:0]  drive_out;
  logic                                clipped;

  modport source (output valid, drive_out, clipped, input ready);
  modport sink   (input valid, drive_out, clipped, output ready);
endinterface

@@ design/pidc_mul.sv @@
// Radix-4 serial multiplier: signed 16-bit multiplier times signed 32-bit
// multiplicand, two multiplier bits per cycle. Depends on pidc_pkg.
module pidc_mul (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [pidc_pkg::DATA_W-1:0]  mplier,
  input  logic signed [pidc_pkg::ACC_W-1:0]   mcand,
  output logic signed [pidc_pkg::PROD_W-1:0]  prod,
  output logic                                done
);

  logic signed [pidc_pkg::PROD_W-1:0]  m1;
  logic signed [pidc_pkg::PROD_W-1:0]  m3;
  logic        [pidc_pkg::DATA_W-1:0]  mr;
  logic        [pidc_pkg::MUL_CNT_W-1:0] cnt;
  logic                                busy;
  logic                                last;
  logic                                sub;
  logic signed [pidc_pkg::PROD_W-1:0]  term;
  logic signed [pidc_pkg::PROD_W-1:0]  ext;
  logic signed [pidc_pkg::PROD_W-1:0]  prod_next;

  assign ext  = pidc_pkg::PROD_W'(mcand);
  assign last = (cnt == pidc_pkg::MUL_CNT_W'(pidc_pkg::MUL_STEPS - 1));

  // Digit select; the top digit carries the sign weight (-2, -1, 0, +1)
  always_comb begin
    term = '0;
    sub  = 1'b0;
    case (mr[pidc_pkg::DIG_W-1:0])
      2'd1: term = m1;
      2'd2: begin
        term = m1 <<< 1;
        sub  = last;
      end
      2'd3: begin
        term = last ? m1 : m3;
        sub  = last;
      end
      default: term = '0;
    endcase
    prod_next = sub ? (prod - term) : (prod + term);
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && last;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath: multiplicands shift up a digit, multiplier shifts down
  always_ff @(posedge clk) begin
    if (start) begin
      m1   <= ext;
      m3   <= ext + (ext <<< 1);
      mr   <= mplier;
      prod <= '0;
      cnt  <= '0;
    end else if (busy) begin
      prod <= prod_next;
      m1   <= m1 <<< pidc_pkg::DIG_W;
      m3   <= m3 <<< pidc_pkg::DIG_W;
      mr   <= mr >> pidc_pkg::DIG_W;
      cnt  <= cnt + 1'b1;
    end
  end

endmodule

@@ design/pidc_div.sv @@
// Restoring bit-serial divider: unsigned 28-bit dividend by 16-bit
// divisor, one quotient bit per cycle. Depends on pidc_pkg.
module pidc_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [pidc_pkg::NUM_W-1:0]         num,
  input  logic [pidc_pkg::DATA_W-1:0]        den,
  output logic [pidc_pkg::NUM_W-1:0]         quo,
  output logic                               busy
);

  logic [pidc_pkg::DATA_W-1:0]    rem;
  logic [pidc_pkg::DATA_W-1:0]    den_r;
  logic [pidc_pkg::DIV_CNT_W-1:0] cnt;
  logic [pidc_pkg::DATA_W:0]      trial;
  logic [pidc_pkg::DATA_W+1:0]    diff;
  logic                           ge;
  logic                           last;

  // One restoring step: bring down the next dividend bit, try the divisor
  always_comb begin
    trial = {rem, quo[pidc_pkg::NUM_W-1]};
    diff  = {1'b0, trial} - {2'b00, den_r};
    ge    = ~diff[pidc_pkg::DATA_W+1];
    last  = (cnt == pidc_pkg::DIV_CNT_W'(pidc_pkg::NUM_W - 1));
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && last) begin
      busy <= 1'b0;
    end
  end

  // Dividend shifts out the top while quotient bits shift in below
  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      den_r <= den;
      rem   <= '0;
      cnt   <= '0;
    end else if (busy) begin
      rem <= ge ? diff[pidc_pkg::DATA_W-1:0] : trial[pidc_pkg::DATA_W-1:0];
      quo <= {quo[pidc_pkg::NUM_W-2:0], ge};
      cnt <= cnt + 1'b1;
    end
  end

endmodule

@@ design/pid_controller_clamped_core.sv @@
// PID controller with saturating integral and clamped output. One sample
// beat (error, time step) yields one control beat. The next sample can be
// accepted in the cycle after the result is registered; no new sample is
// taken while one is being worked on. After the sample accept, the shared
// radix-4 multiplier forms four products (e*dt, kp*e, ki*I, kd*D) in turn,
// and the clamp follows. The derivative divider runs alongside and is
// finished before the kd product needs it. A zero time step gives a zero
// derivative and leaves the integral unchanged. The output register lets a
// finished control beat wait for the sink while the next sample is worked
// on. Registers are written over APB at byte offsets 0,4,8,12,16.
module pid_controller_clamped_core (
  input  logic                               clk,
  input  logic                               rst,
  pidc_sample_if.sink                        sample,
  pidc_control_if.source                     control,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pidc_pkg::ADDR_W-1:0]        paddr,
  input  logic [pidc_pkg::PDATA_W-1:0]       pwdata,
  output logic [pidc_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready
);

  localparam int DW = pidc_pkg::DATA_W;
  localparam int AW = pidc_pkg::ACC_W;
  localparam int PW = pidc_pkg::PROD_W;

  // Configuration
  logic signed [DW-1:0] gain_prop;
  logic signed [DW-1:0] gain_integ;
  logic signed [DW-1:0] gain_deriv;
  logic signed [DW-1:0] out_max;
  logic signed [DW-1:0] out_min;

  // Controller state and per-item working registers
  logic signed [DW-1:0] prev_err;
  logic signed [AW-1:0] integ_acc;
  logic signed [DW-1:0] e_r;
  logic        [DW-1:0] dt_r;
  logic                 dneg;
  logic signed [PW-1:0] sum;
  pidc_pkg::state_t     state;
  pidc_pkg::op_t        op;
  logic                 mul_start;

  // Output register
  logic                 out_valid;
  logic signed [DW-1:0] drive_r;
  logic                 clip_r;

  // Unit connections
  logic signed [DW-1:0]             mplier;
  logic signed [AW-1:0]             mcand;
  logic signed [PW-1:0]             prod;
  logic                             mul_done;
  logic [pidc_pkg::NUM_W-1:0]       quo;
  logic                             div_busy;
  logic signed [DW:0]               diff;
  logic [DW-1:0]                    diff_mag;
  logic [pidc_pkg::NUM_W-1:0]       div_num;
  logic signed [pidc_pkg::DERIV_W-1:0] deriv;

  logic                 in_fire;
  logic                 out_fire;
  logic                 cfg_wr;
  logic                 out_free;
  logic signed [PW-1:0] ishift;
  logic signed [AW+1:0] isum;
  logic signed [PW-1:0] ctl;
  logic signed [PW-1:0] max_ext;
  logic signed [PW-1:0] min_ext;

  assign in_fire  = sample.valid && sample.ready;
  assign out_fire = control.valid && control.ready;
  assign out_free = !out_valid || control.ready;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;

  assign sample.ready      = (state == pidc_pkg::S_IDLE);
  assign control.valid     = out_valid;
  assign control.drive_out = drive_r;
  assign control.clipped   = clip_r;

  // APB write
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_prop  <= '0;
      gain_integ <= '0;
      gain_deriv <= '0;
      out_max    <= {1'b0, {(DW-1){1'b1}}};
      out_min    <= {1'b1, {(DW-1){1'b0}}};
    end else if (cfg_wr) begin
      unique case (pidc_pkg::reg_idx_t'(paddr[pidc_pkg::ADDR_W-1:2]))
        pidc_pkg::REG_GAIN_PROP:  gain_prop  <= pwdata[DW-1:0];
        pidc_pkg::REG_GAIN_INTEG: gain_integ <= pwdata[DW-1:0];
        pidc_pkg::REG_GAIN_DERIV: gain_deriv <= pwdata[DW-1:0];
        pidc_pkg::REG_OUT_MAX:    out_max    <= pwdata[DW-1:0];
        pidc_pkg::REG_OUT_MIN:    out_min    <= pwdata[DW-1:0];
        default: ;
      endcase
    end
  end

  // APB read, sign-extended
  always_comb begin
    unique case (pidc_pkg::reg_idx_t'(paddr[pidc_pkg::ADDR_W-1:2]))
      pidc_pkg::REG_GAIN_PROP:  prdata = pidc_pkg::PDATA_W'(gain_prop);
      pidc_pkg::REG_GAIN_INTEG: prdata = pidc_pkg::PDATA_W'(gain_integ);
      pidc_pkg::REG_GAIN_DERIV: prdata = pidc_pkg::PDATA_W'(gain_deriv);
      pidc_pkg::REG_OUT_MAX:    prdata = pidc_pkg::PDATA_W'(out_max);
      pidc_pkg::REG_OUT_MIN:    prdata = pidc_pkg::PDATA_W'(out_min);
      default:                  prdata = '0;
    endcase
  end

  // Derivative dividend: |e - prev_err| scaled by 2^12, sign kept aside
  always_comb begin
    diff     = (DW+1)'(sample.err_sample) - (DW+1)'(prev_err);
    diff_mag = diff[DW] ? DW'(-diff) : DW'(diff);
    div_num  = {diff_mag, {pidc_pkg::FRAC_DT{1'b0}}};
  end

  pidc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (in_fire),
    .num   (div_num),
    .den   (sample.step_time),
    .quo   (quo),
    .busy  (div_busy)
  );

  // Signed quotient, truncated toward zero; zero step means no derivative
  always_comb begin
    if (dt_r == '0) begin
      deriv = '0;
    end else if (dneg) begin
      deriv = -$signed({1'b0, quo});
    end else begin
      deriv = $signed({1'b0, quo});
    end
  end

  // Operand select for the shared multiplier
  always_comb begin
    case (op)
      pidc_pkg::OP_EDT: begin
        mplier = e_r;
        mcand  = $signed(AW'(dt_r));
      end
      pidc_pkg::OP_KP: begin
        mplier = gain_prop;
        mcand  = AW'(e_r);
      end
      pidc_pkg::OP_KI: begin
        mplier = gain_integ;
        mcand  = integ_acc;
      end
      default: begin
        mplier = gain_deriv;
        mcand  = AW'(deriv);
      end
    endcase
  end

  pidc_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .mplier (mplier),
    .mcand  (mcand),
    .prod   (prod),
    .done   (mul_done)
  );

  // Integral step (floor >> 4) and output scaling (floor >> 8)
  always_comb begin
    ishift  = prod >>> 4;
    isum    = (AW+2)'(integ_acc) + $signed(ishift[AW+1:0]);
    ctl     = sum >>> 8;
    max_ext = PW'(out_max);
    min_ext = PW'(out_min);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pidc_pkg::S_IDLE;
      op        <= pidc_pkg::OP_EDT;
      mul_start <= 1'b0;
      out_valid <= 1'b0;
      prev_err  <= '0;
      integ_acc <= '0;
    end else begin
      mul_start <= 1'b0;
      if (out_fire) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        pidc_pkg::S_IDLE: begin
          if (in_fire) begin
            prev_err  <= sample.err_sample;
            op        <= pidc_pkg::OP_EDT;
            mul_start <= 1'b1;
            state     <= pidc_pkg::S_MUL;
          end
        end
        pidc_pkg::S_MUL: begin
          if (mul_done) begin
            case (op)
              pidc_pkg::OP_EDT: begin
                integ_acc <= pidc_pkg::sat_acc(isum);
                op        <= pidc_pkg::OP_KP;
                mul_start <= 1'b1;
              end
              pidc_pkg::OP_KP: begin
                op        <= pidc_pkg::OP_KI;
                mul_start <= 1'b1;
              end
              pidc_pkg::OP_KI: begin
                op <= pidc_pkg::OP_KD;
                if (div_busy) begin
                  state <= pidc_pkg::S_WDIV;
                end else begin
                  mul_start <= 1'b1;
                end
              end
              default: state <= pidc_pkg::S_CLAMP;
            endcase
          end
        end
        pidc_pkg::S_WDIV: begin
          if (!div_busy) begin
            mul_start <= 1'b1;
            state     <= pidc_pkg::S_MUL;
          end
        end
        pidc_pkg::S_CLAMP: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= pidc_pkg::S_IDLE;
          end
        end
        default: state <= pidc_pkg::S_IDLE;
      endcase
    end
  end

  // Per-item payload: captured sample, running sum, result
  always_ff @(posedge clk) begin
    if (in_fire) begin
      e_r  <= sample.err_sample;
      dt_r <= sample.step_time;
      dneg <= diff[DW];
    end
    if (state == pidc_pkg::S_MUL && mul_done) begin
      case (op)
        pidc_pkg::OP_KP: sum <= prod;
        pidc_pkg::OP_KI: sum <= sum + (prod >>> 8);
        pidc_pkg::OP_KD: sum <= sum + prod;
        default: ;
      endcase
    end
    if (state == pidc_pkg::S_CLAMP && out_free) begin
      if (ctl > max_ext) begin
        drive_r <= out_max;
        clip_r  <= 1'b1;
      end else if (ctl < min_ext) begin
        drive_r <= out_min;
        clip_r  <= 1'b1;
      end else begin
        drive_r <= ctl[DW-1:0];
        clip_r  <= 1'b0;
      end
    end
  end

endmodule

@@ dv/tb_pid_controller_clamped_core.sv @@
// Testbench for pid_controller_clamped_core: directed table, then random runs
// of samples under changing gains and limits, checked beat by beat against the table or a
// local model of the controller. Depends on pidc_pkg and the pidc stream interfaces.
module tb_pid_controller_clamped_core;
  timeunit 1ns;
  timeprecision 1ps;
  import pidc_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic                     clip;
  } ctrl_beat_t;

  typedef enum bit {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct {
    row_kind_t                kind;
    reg_idx_t                 idx;
    logic [DATA_W-1:0]        value;
    logic signed [DATA_W-1:0] err;
    logic [DATA_W-1:0]        dt;
    bit                       typed;
    ctrl_beat_t               beat;
  } plan_row_t;

  typedef enum logic [1:0] {
    RUN_NOISE,
    RUN_SMOOTH,
    RUN_SATURATE,
    RUN_FINE_STEP
  } run_kind_t;

  localparam longint ACC_HI = 64'sd2147483647;
  localparam longint ACC_LO = -64'sd2147483648;

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_W-1:0]    paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  pidc_sample_if  sample_bus ();
  pidc_control_if control_bus ();

  pid_controller_clamped_core DUT (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_bus),
    .control (control_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow registers and controller state
  logic signed [DATA_W-1:0] kp, ki, kd, lim_hi, lim_lo;
  logic signed [DATA_W-1:0] err_last;
  logic signed [ACC_W-1:0]  integ_sum;

  ctrl_beat_t  control_due[$];
  plan_row_t   plan[$];
  int unsigned items_sent;
  int unsigned beats_seen;
  int unsigned errors;
  bit          no_gaps;

  // One controller step: integral, derivative, weighted sum, clamp
  function automatic ctrl_beat_t next_control(logic signed [DATA_W-1:0] e,
                                              logic [DATA_W-1:0] dt);
    longint     ev, dv, acc, rate, total, ctl;
    ctrl_beat_t r;
    ev = e;
    dv = dt;
    acc = longint'(integ_sum) + ((ev * dv) >>> 4);
    if (acc > ACC_HI) acc = ACC_HI;
    if (acc < ACC_LO) acc = ACC_LO;
    integ_sum = acc[ACC_W-1:0];
    // division truncates toward zero, as the derivative wants
    rate = (dv != 0) ? ((ev - longint'(err_last)) * 4096) / dv : 64'sd0;
    total = longint'(kp) * ev
          + ((longint'(ki) * longint'(integ_sum)) >>> 8)
          + longint'(kd) * rate;
    ctl = total >>> 8;
    r.clip = 1'b0;
    // upper limit wins when the limits are inverted
    if (ctl > longint'(lim_hi)) begin
      ctl = lim_hi;
      r.clip = 1'b1;
    end else if (ctl < longint'(lim_lo)) begin
      ctl = lim_lo;
      r.clip = 1'b1;
    end
    r.drive = ctl[DATA_W-1:0];
    err_last = e;
    return r;
  endfunction

  function automatic void plan_write(reg_idx_t idx, logic [DATA_W-1:0] value);
    plan_row_t r;
    r.kind  = ROW_WRITE;
    r.idx   = idx;
    r.value = value;
    r.err   = '0;
    r.dt    = '0;
    r.typed = 1'b0;
    r.beat  = '0;
    plan.push_back(r);
  endfunction

  function automatic void plan_item(logic signed [DATA_W-1:0] e, logic [DATA_W-1:0] dt,
                                    bit typed, logic signed [DATA_W-1:0] drive, bit clip);
    plan_row_t r;
    r.kind       = ROW_SAMPLE;
    r.idx        = REG_GAIN_PROP;
    r.value      = '0;
    r.err        = e;
    r.dt         = dt;
    r.typed      = typed;
    r.beat.drive = drive;
    r.beat.clip  = clip;
    plan.push_back(r);
  endfunction

  // Gains lean to small values, with the extremes mixed in
  function automatic logic [DATA_W-1:0] pick_gain();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return 16'h7FFF;
    else if (roll < 20) return 16'h8000;
    else if (roll < 25) return 16'h0000;
    else if (roll < 50) return 16'($urandom);
    else return 16'($urandom_range(1024) - 512);
  endfunction

  task automatic note_error(string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // APB write, only once all control beats are back
  task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
    sample_bus.valid = 1'b0;
    while (control_due.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {{(PDATA_W-DATA_W){value[DATA_W-1]}}, value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_GAIN_PROP:  kp = value;
      REG_GAIN_INTEG: ki = value;
      REG_GAIN_DERIV: kd = value;
      REG_OUT_MAX:    lim_hi = value;
      REG_OUT_MIN:    lim_lo = value;
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Drive one sample beat; valid stays up afterwards unless a gap follows
  task automatic send_sample(logic signed [DATA_W-1:0] e, logic [DATA_W-1:0] dt,
                             bit typed, ctrl_beat_t typed_beat);
    ctrl_beat_t want;
    no_gaps = (items_sent >= 600 && items_sent < 760);
    while (!no_gaps && $urandom_range(99) < 27) begin
      sample_bus.valid = 1'b0;
      @(negedge clk);
    end
    sample_bus.valid      = 1'b1;
    sample_bus.err_sample = e;
    sample_bus.step_time  = dt;
    do @(posedge clk); while (!sample_bus.ready);
    want = next_control(e, dt);
    control_due.push_back(typed ? typed_beat : want);
    items_sent++;
    @(negedge clk);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Sink stalls
  always @(negedge clk) begin
    control_bus.ready = no_gaps || ($urandom_range(99) >= 27);
  end

  // Compare each control beat with the oldest expectation
  always @(posedge clk) begin : check_control
    ctrl_beat_t want;
    if (!rst && control_bus.valid && control_bus.ready) begin
      if (control_due.size() == 0) begin
        note_error($sformatf("unexpected control beat: drive_out %0d clipped %0b",
                             control_bus.drive_out, control_bus.clipped));
      end else begin
        want = control_due.pop_front();
        if (control_bus.drive_out !== want.drive)
          note_error($sformatf("beat %0d: drive_out exp %0d got %0d",
                               beats_seen, want.drive, control_bus.drive_out));
        if (control_bus.clipped !== want.clip)
          note_error($sformatf("beat %0d: clipped exp %0b got %0b",
                               beats_seen, want.clip, control_bus.clipped));
      end
      beats_seen++;
    end
  end

  // Stimulus
  initial begin : stimulus
    run_kind_t                kind;
    int unsigned              len, roll;
    int                       walk, v;
    bit                       s;
    logic signed [DATA_W-1:0] e, a, b;
    logic [DATA_W-1:0]        dt;

    rst                   = 1'b1;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    sample_bus.valid      = 1'b0;
    sample_bus.err_sample = '0;
    sample_bus.step_time  = '0;
    control_bus.ready     = 1'b0;
    no_gaps               = 1'b0;
    items_sent            = 0;
    beats_seen            = 0;
    errors                = 0;
    kp       = '0;
    ki       = '0;
    kd       = '0;
    lim_hi   = 16'sh7FFF;
    lim_lo   = 16'sh8000;
    err_last = '0;
    integ_sum = '0;

    // Directed table. Reset gains are zero, so everything drives zero.
    plan_item(16'sh0000, 16'h0000, 1, 16'sh0000, 0);
    plan_item(16'sh7FFF, 16'hFFFF, 1, 16'sh0000, 0);
    plan_item(16'sh8000, 16'hFFFF, 1, 16'sh0000, 0);
    plan_item(16'sh8000, 16'h0000, 1, 16'sh0000, 0);
    // largest positive proportional gain: both rails
    plan_write(REG_GAIN_PROP, 16'h7FFF);
    plan_item(16'sh7FFF, 16'h0000, 1, 16'sh7FFF, 1);
    plan_item(16'sh8000, 16'h0000, 1, 16'sh8000, 1);
    plan_item(16'sh0001, 16'h0001, 0, 16'sh0000, 0);
    // most negative proportional gain flips the rails
    plan_write(REG_GAIN_PROP, 16'h8000);
    plan_item(16'sh7FFF, 16'h0000, 1, 16'sh8000, 1);
    plan_item(16'sh8000, 16'h0000, 1, 16'sh7FFF, 1);
    // unit gain with inverted limits: upper limit checked first
    plan_write(REG_GAIN_PROP, 16'h0100);
    plan_write(REG_OUT_MAX, 16'hFF9C);
    plan_write(REG_OUT_MIN, 16'h0064);
    plan_item(16'sh0000, 16'h0000, 1, -16'sd100, 1);
    plan_item(-16'sd200, 16'h0000, 1, 16'sd100, 1);
    plan_item(-16'sd100, 16'h0000, 1, 16'sd100, 1);
    // derivative only, full limits; zero step kills the derivative
    plan_write(REG_OUT_MAX, 16'h7FFF);
    plan_write(REG_OUT_MIN, 16'h8000);
    plan_write(REG_GAIN_PROP, 16'h0000);
    plan_write(REG_GAIN_DERIV, 16'h7FFF);
    plan_item(16'sh7FFF, 16'h0001, 0, 16'sh0000, 0);
    plan_item(16'sh8000, 16'h0001, 0, 16'sh0000, 0);
    plan_item(16'sd500, 16'h0000, 0, 16'sh0000, 0);
    plan_item(16'sd500, 16'hFFFF, 0, 16'sh0000, 0);
    plan_write(REG_GAIN_DERIV, 16'h8000);
    plan_item(16'sh8000, 16'h0001, 0, 16'sh0000, 0);
    plan_item(16'sh7FFF, 16'h0002, 0, 16'sh0000, 0);
    // integral only
    plan_write(REG_GAIN_DERIV, 16'h0000);
    plan_write(REG_GAIN_INTEG, 16'h7FFF);
    plan_item(16'sh7FFF, 16'hFFFF, 0, 16'sh0000, 0);
    plan_item(16'sh0000, 16'h0000, 0, 16'sh0000, 0);
    plan_item(16'sh8000, 16'hFFFF, 0, 16'sh0000, 0);
    plan_item(16'sh0001, 16'h1000, 0, 16'sh0000, 0);
    plan_write(REG_GAIN_INTEG, 16'h8000);
    plan_item(-16'sd1, 16'h0010, 0, 16'sh0000, 0);
    plan_item(16'sd256, 16'h1000, 0, 16'sh0000, 0);

    repeat (3) @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        write_reg(plan[i].idx, plan[i].value);
      end else begin
        send_sample(plan[i].err, plan[i].dt, plan[i].typed, plan[i].beat);
      end
    end

    // Random runs; before each, gains and limits may be rewritten
    while (items_sent < 1300) begin
      if ($urandom_range(99) < 60) write_reg(REG_GAIN_PROP, pick_gain());
      if ($urandom_range(99) < 60) write_reg(REG_GAIN_INTEG, pick_gain());
      if ($urandom_range(99) < 60) write_reg(REG_GAIN_DERIV, pick_gain());
      roll = $urandom_range(99);
      if (roll < 70) begin
        if (roll < 30) begin
          a = 16'sh7FFF;
          b = 16'sh8000;
        end else if (roll < 55) begin
          a = 16'($urandom_range(2000));
          b = -16'($urandom_range(2000));
        end else begin
          a = 16'($urandom);
          b = 16'($urandom);
          if (a < b) begin
            e = a;
            a = b;
            b = e;
          end
        end
        write_reg(REG_OUT_MAX, a);
        write_reg(REG_OUT_MIN, b);
      end else if (roll < 85) begin
        // inverted limits
        a = 16'($urandom);
        b = 16'($urandom);
        write_reg(REG_OUT_MAX, (a < b) ? a : b);
        write_reg(REG_OUT_MIN, (a < b) ? b : a);
      end

      kind = run_kind_t'($urandom_range(3));
      len  = (kind == RUN_SATURATE) ? 50 : $urandom_range(40, 10);
      walk = err_last;
      s    = $urandom_range(1);
      for (int k = 0; k < len; k++) begin
        case (kind)
          RUN_NOISE: begin
            e  = 16'($urandom);
            dt = ($urandom_range(9) == 0) ? 16'h0000 : 16'($urandom);
          end
          RUN_SMOOTH: begin
            walk = walk + int'($urandom_range(128)) - 64;
            if (walk > 32767) walk = 32767;
            if (walk < -32768) walk = -32768;
            e  = walk[DATA_W-1:0];
            dt = ($urandom_range(19) == 0) ? 16'h0000 : 16'(4096 + $urandom_range(512));
          end
          RUN_SATURATE: begin
            // same-sign errors drive the integral into its rail, then back out
            v  = (s ^ (k >= 40)) ? (-32768 + int'($urandom_range(2047)))
                                 : (32767 - int'($urandom_range(2047)));
            e  = v[DATA_W-1:0];
            dt = 16'(65535 - $urandom_range(4095));
          end
          default: begin
            e  = 16'($urandom);
            dt = 16'($urandom_range(15));
          end
        endcase
        send_sample(e, dt, 1'b0, '0);
      end
    end

    sample_bus.valid = 1'b0;
    while (control_due.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
